FILE: rtl/med_pkg.sv
// Shared sizes, sample type and controller/datapath command and status
// structs for the median-of-N filter. No dependencies.
package med_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_W       = 5;
  localparam int FILL_W      = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CMP_W       = ((FILL_W > CFG_W) ? FILL_W : CFG_W) + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(5);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Controller to datapath
  typedef struct packed {
    logic insert;   // insert the input sample into the sorted store
    logic load_lo;  // capture the lower middle entry
    logic emit;     // form the median, load the output register, empty the store
  } med_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic close;     // the sample being inserted completes the window
    logic out_free;  // the output register can take a new median
  } med_sts_t;

endpackage

FILE: rtl/median_of_n_samples_unit.sv
// Median-of-N filter top level: joins the controller and the datapath.
// Depends on med_pkg, med_ctrl and med_datapath.
//
// Usage:
//   Input channel in_valid/in_ready/in_sample carries one signed sample per
//   transfer. Every sample is inserted into an ascending store in the cycle
//   of its transfer by a row of compare-and-shift cells.
//   When the store holds the window length set by cfg_wr_data (0 acts as 1,
//   values above capacity saturate), the median goes out on the result
//   channel out_valid/out_ready/out_median and the store is emptied.
//   Throughput: one sample per cycle while a window fills; the sample that
//   closes a window holds off input while the two middle entries are read
//   through the single store read port. The median is registered after the
//   lower middle entry is captured and once the output register is free.
//   A stalled receiver holds off the next median and, once a window closes,
//   the input: the output register keeps it until taken, and the closing state waits for a free register.
//   Reset (rst_n low, synchronous) empties the store and sets the window
//   length to 5. Write cfg_wr_en/cfg_wr_data only while the block is idle.
module median_of_n_samples_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [med_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  med_pkg::sample_t          in_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output med_pkg::sample_t          out_median
);
  import med_pkg::*;

  med_cmd_t cmd;
  med_sts_t sts;

  med_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  med_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_sample   (in_sample),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_median  (out_median)
  );

`ifndef NO_ASSERTIONS
  // A sample that does not close the window leaves the input open
  a_open_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !sts.close) |=> in_ready)
    else $error("input closed after a non-closing sample");

  // The closing sample blocks input while the median is formed
  a_busy_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.close) |=> !in_ready)
    else $error("input open right after the closing sample");

  // A formed median is presented on the next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("median formed but not presented");
`endif

endmodule

FILE: rtl/med_ctrl.sv
// Controller for the median-of-N filter: sequences insert, middle-entry
// reads and median hand-off. Depends on med_pkg.
module med_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  med_pkg::med_sts_t sts,
  output med_pkg::med_cmd_t cmd
);
  import med_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  // Decode commands from the current state
  always_comb begin
    cmd.insert  = in_valid && in_ready_r;
    cmd.load_lo = (state_r == S_RD_LO);
    cmd.emit    = (state_r == S_RD_HI) && sts.out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.insert && sts.close) state_nxt = S_RD_LO;
      end
      S_RD_LO: state_nxt = S_RD_HI;
      S_RD_HI: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

FILE: rtl/med_datapath.sv
// Datapath for the median-of-N filter: compare-and-shift sorted store,
// fill counter, window-length register and output register. Depends on med_pkg.
module med_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [med_pkg::CFG_W-1:0] cfg_wr_data,
  input  med_pkg::sample_t       in_sample,
  input  med_pkg::med_cmd_t      cmd,
  output med_pkg::med_sts_t      sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output med_pkg::sample_t       out_median
);
  import med_pkg::*;

  sample_t                 store_r [MAX_SAMPLES];
  sample_t                 store_nxt [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0]  gt;
  logic [FILL_W-1:0]       filled_r;
  logic [CFG_W-1:0]        count_r;
  logic [CMP_W-1:0]        win_len;
  logic [CMP_W-1:0]        fill_inc;
  logic [FILL_W-1:0]       lo_pos;
  logic [FILL_W-1:0]       hi_pos;
  logic [IDX_W-1:0]        rd_idx;
  sample_t                 rd_data;
  sample_t                 lo_r;
  logic signed [SAMPLE_W:0] sum;
  logic                    out_valid_r;
  sample_t                 out_median_r;

  // Window length: zero acts as one, saturate at capacity
  always_comb begin
    if (count_r == '0) begin
      win_len = CMP_W'(1);
    end else if (CMP_W'(count_r) > CMP_W'(MAX_SAMPLES)) begin
      win_len = CMP_W'(MAX_SAMPLES);
    end else begin
      win_len = CMP_W'(count_r);
    end
  end

  assign fill_inc     = CMP_W'(filled_r) + CMP_W'(1);
  assign sts.close    = (fill_inc >= win_len);
  assign sts.out_free = !out_valid_r || out_ready;

  // Compare-and-shift cells: entries above the key move up one place
  always_comb begin
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      gt[i] = (FILL_W'(i) < filled_r) && (store_r[i] > in_sample);
    end
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        store_nxt[i] = store_r[(i > 0) ? i - 1 : 0];
      end else if (gt[i] || (FILL_W'(i) == filled_r)) begin
        store_nxt[i] = in_sample;
      end else begin
        store_nxt[i] = store_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

  // Middle positions of a window of filled_r entries (equal for odd sizes)
  assign lo_pos  = (filled_r - FILL_W'(1)) >> 1;
  assign hi_pos  = filled_r >> 1;
  assign rd_idx  = cmd.load_lo ? lo_pos[IDX_W-1:0] : hi_pos[IDX_W-1:0];
  assign rd_data = store_r[rd_idx];

  // Floored mean: drop the low bit of the widened sum
  assign sum = {lo_r[SAMPLE_W-1], lo_r} + {rd_data[SAMPLE_W-1], rd_data};

  always_ff @(posedge clk) begin
    if (cmd.load_lo) lo_r <= rd_data;
    if (cmd.emit) out_median_r <= sum[SAMPLE_W:1];
  end

  // Control state: fill count, window register, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      count_r     <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) count_r <= cfg_wr_data;
      if (cmd.emit) begin
        filled_r <= '0;
      end else if (cmd.insert) begin
        filled_r <= fill_inc[FILL_W-1:0];
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

endmodule

FILE: bench/median_of_n_samples_unit_tb.sv
// Testbench for the median-of-N filter: drives samples with random bursts and
// gaps, stalls the result side, and checks every median against a local model.
// Depends on med_pkg and median_of_n_samples_unit.
module median_of_n_samples_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import med_pkg::*;

  logic             clk;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  sample_t          in_sample   = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  sample_t          out_median;

  median_of_n_samples_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_median  (out_median)
  );

  // Sample styles for the random part
  localparam int STYLE_WIDE    = 0;
  localparam int STYLE_NARROW  = 1;
  localparam int STYLE_EXTREME = 2;
  localparam int STYLE_MIXED   = 3;

  localparam int SETTLE_CYCLES = 8;

  // Samples waiting for the driver, medians waiting for the monitor
  sample_t     pending_samples[$];
  sample_t     expected_medians[$];

  // Shadow of the filter: ascending store, fill level, window setting
  sample_t     sorted_copy[MAX_SAMPLES];
  int unsigned held_count    = 0;
  logic [CFG_W-1:0] window_cfg = CFG_RESET;

  int unsigned samples_sent  = 0;
  int unsigned medians_seen  = 0;
  int unsigned cfg_writes    = 0;
  int unsigned fail_count    = 0;

  // Sender burst state, receiver stall state
  int unsigned burst_left    = 1;
  int unsigned gap_left      = 0;
  int unsigned stall_mode    = 0;
  int unsigned mode_left     = 0;
  int unsigned hold_left     = 0;
  int unsigned hold_request  = 0;
  int unsigned ready_tick    = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Insert one sample into the shadow store; queue a median when the window closes
  function automatic void insert_and_take_median(sample_t s);
    int unsigned pos;
    int unsigned win_len;
    logic signed [SAMPLE_W:0] pair_sum;
    sample_t med;
    pos = (held_count >= MAX_SAMPLES) ? MAX_SAMPLES - 1 : held_count;
    while (pos > 0 && sorted_copy[pos-1] > s) begin
      sorted_copy[pos] = sorted_copy[pos-1];
      pos--;
    end
    sorted_copy[pos] = s;
    if (held_count < MAX_SAMPLES) held_count++;
    win_len = (window_cfg == 0) ? 1 : ((window_cfg > MAX_SAMPLES) ? MAX_SAMPLES : window_cfg);
    if (held_count >= win_len) begin
      if (held_count % 2 == 1) begin
        med = sorted_copy[held_count/2];
      end else begin
        pair_sum = sorted_copy[held_count/2 - 1] + sorted_copy[held_count/2];
        med = sample_t'(pair_sum >>> 1);
      end
      expected_medians.push_back(med);
      held_count = 0;
    end
  endfunction

  function automatic sample_t pick_sample(int style);
    int sel;
    sel = (style == STYLE_MIXED) ? $urandom_range(0, 2) : style;
    case (sel)
      STYLE_NARROW: return sample_t'(int'($urandom_range(0, 15)) - 8);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 5))
          0: return sample_t'(16'sh7fff);
          1: return sample_t'(16'sh8000);
          2: return sample_t'(16'sh7ffe);
          3: return sample_t'(16'sh8001);
          4: return sample_t'(-1);
          default: return sample_t'($urandom());
        endcase
      end
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic void note_failure(string what, sample_t want, sample_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] %s: expected %0d actual %0d", $realtime, what, want, got);
  endfunction

  // Driver: offer pending samples in bursts, predict on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        insert_and_take_median(in_sample);
        samples_sent++;
      end
      // Hold the payload while a transfer is still outstanding
      if (!(in_valid && !in_ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_sample <= pending_samples.pop_front();
          in_valid  <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each median transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      medians_seen++;
      if (expected_medians.size() == 0)
        note_failure("median with none pending", '0, out_median);
      else if (expected_medians[0] !== out_median) begin
        note_failure("median mismatch", expected_medians[0], out_median);
        void'(expected_medians.pop_front());
      end else begin
        void'(expected_medians.pop_front());
      end
    end
    ready_tick++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (ready_tick % 5 == 0);
      endcase
    end
  end

  // Pause the sender until every transfer is done and every median is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_medians.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    window_cfg  = value;
    cfg_writes++;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_samples(int count, int style);
    repeat (count) pending_samples.push_back(pick_sample(style));
  endtask

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned drain_wait;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset window of five, field extremes
    pending_samples = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1};

    // Pairs: floored negative mean, sum wider than a sample, equal entries
    write_window(5'd2);
    pending_samples = '{-16'sd3, -16'sd2, 16'sh7fff, 16'sh7fff,
                        16'sh8000, 16'sh8000, 16'sd9, 16'sd9};

    // Zero count acts as one
    write_window(5'd0);
    pending_samples = '{16'sh8000, 16'sd12345, 16'sh7fff};

    // Lower the count mid-window: four held samples close a window of two
    write_window(5'd4);
    pending_samples = '{16'sd100, -16'sd5, 16'sd40};
    write_window(5'd2);
    pending_samples = '{16'sd7};

    // Window of one with a long receiver hold-off so the input backs up
    write_window(5'd1);
    queue_samples(130, STYLE_WIDE);
    hold_request = 300;

    write_window(5'd31);
    queue_samples(130, STYLE_MIXED);
    write_window(5'd16);
    queue_samples(130, STYLE_NARROW);
    write_window(5'd17);
    queue_samples(130, STYLE_EXTREME);
    write_window(5'd3);
    queue_samples(130, STYLE_MIXED);
    write_window(5'd8);
    queue_samples(130, STYLE_WIDE);
    hold_request = 200;
    write_window(5'd0);
    queue_samples(130, STYLE_MIXED);
    write_window(5'd15);
    queue_samples(130, STYLE_NARROW);
    write_window(5'd6);
    queue_samples(130, STYLE_EXTREME);
    write_window(5'd2);
    queue_samples(130, STYLE_MIXED);
    write_window(5'd11);
    queue_samples(130, STYLE_WIDE);
    write_window(CFG_W'($urandom_range(1, 31)));
    queue_samples(130, STYLE_MIXED);

    // Let the last transfers finish, then give outstanding medians a bounded wait
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid);
    drain_wait = 0;
    while (expected_medians.size() != 0 && drain_wait < 5000) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (expected_medians.size() != 0)
      note_failure("median never delivered", expected_medians.pop_front(), '0);

    $display("Run covered %0d samples, %0d medians, %0d window-length writes.",
             samples_sent, medians_seen, cfg_writes);
    $display("Failures counted: %0d", fail_count);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/med_pkg.sv
rtl/med_ctrl.sv
rtl/med_datapath.sv
rtl/median_of_n_samples_unit.sv
bench/median_of_n_samples_unit_tb.sv
